@@ sv/btpc_pkg.sv @@
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants shared by the compensation core and its interfaces.
// ----------------------------------------------------------------------------
package btpc_pkg;

   localparam int CsrWidth  = 64;
   localparam int CsrIdxW   = 2;
   localparam int RawWidth  = 20;

   localparam logic [1:0] CSR_TEMP_CAL    = 2'd0;
   localparam logic [1:0] CSR_PRESS_CAL_A = 2'd1;
   localparam logic [1:0] CSR_PRESS_CAL_B = 2'd2;
   localparam logic [1:0] CSR_PRESS_CAL_C = 2'd3;

   localparam logic REQ_TEMP  = 1'b0;
   localparam logic REQ_PRESS = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [RawWidth-1:0] raw_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] temperature_centideg;
      logic [31:0]        pressure_pa;
      logic               divide_by_zero;
   } rsp_payload_type;

   // sequencer states; most steps use the shared multiplier, ST_PDIV is the serial divider
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
      ST_PDIV, ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14,
      ST_DONE
   } state_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // arithmetic right shift kept self-contained so unsigned neighbors
   // in a sum cannot turn it into a logical shift
   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      return $signed(x) >>> n;
   endfunction

endpackage

@@ sv/btpc_if.sv @@
// ----------------------------------------------------------------------------
// btpc_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface btpc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/baro_temp_pressure_compensation_core.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Integer temperature / pressure compensation with a shared 32x32 multiplier
// and a radix-2 serial divider.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_type, raw_sample
//  rsp     | out | temperature_centideg, pressure_pa, divide_by_zero
//  csr     | in  | csr_we, csr_idx, csr_wdata (write only)
//
//  Temperature: uses the shared multiplier only, no divide.
//  Pressure: runs the serial divider, which is skipped on a zero divisor.
//  Synchronous active-high reset clears calibration and fine temperature.
//  req is not ready while a transaction is in work or a result is unread.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core
   import btpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   btpc_if.sink                req,
   btpc_if.source              rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_idx,
   input  logic [CsrWidth-1:0] csr_wdata
);

   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff, press_cal_b_ff;
   logic [15:0] press_cal_c_ff;
   logic [31:0] fine_ff, fine_in;

   state_type   state_ff, state_in;
   logic [19:0] adc_ff, adc_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;   // scratch registers
   logic [31:0] prod_ff;                              // registered multiplier output
   logic [31:0] ma, mb;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;
   logic        rvalid_ff, rvalid_in;
   rsp_payload_type res_ff, res_in;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [32:0] trial;

   assign t1 = {16'd0, temp_cal_ff[15:0]};
   assign t2 = sx16(temp_cal_ff[31:16]);
   assign t3 = sx16(temp_cal_ff[47:32]);
   assign p1 = {16'd0, press_cal_a_ff[15:0]};
   assign p2 = sx16(press_cal_a_ff[31:16]);
   assign p3 = sx16(press_cal_a_ff[47:32]);
   assign p4 = sx16(press_cal_a_ff[63:48]);
   assign p5 = sx16(press_cal_b_ff[15:0]);
   assign p6 = sx16(press_cal_b_ff[31:16]);
   assign p7 = sx16(press_cal_b_ff[47:32]);
   assign p8 = sx16(press_cal_b_ff[63:48]);
   assign p9 = sx16(press_cal_c_ff);

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.data  = res_ff;

   // divider step: divisor held in c_ff, dividend shifted out of quo_ff
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, c_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rvalid_ff      <= 1'b0;
         fine_ff        <= '0;
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         fine_ff   <= fine_in;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_TEMP_CAL:    temp_cal_ff    <= csr_wdata[47:0];
               CSR_PRESS_CAL_A: press_cal_a_ff <= csr_wdata;
               CSR_PRESS_CAL_B: press_cal_b_ff <= csr_wdata;
               CSR_PRESS_CAL_C: press_cal_c_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      adc_ff  <= adc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
      prod_ff <= 32'(ma * mb);
   end

   always_comb begin
      state_in  = state_ff;
      rvalid_in = rvalid_ff;
      fine_in   = fine_ff;
      adc_in    = adc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      res_in    = res_ff;
      ma        = '0;
      mb        = '0;
      if (rsp.valid && rsp.ready) rvalid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               adc_in = req.data.raw_sample;
               res_in = '0;
               state_in = (req.data.req_type == REQ_PRESS) ? ST_P0 : ST_T0;
            end
         end
         // ---------------- temperature ----------------
         ST_T0: begin
            ma = {15'd0, adc_ff[19:3]} - (t1 << 1); mb = t2;
            a_in = {16'd0, adc_ff[19:4]} - t1;   // d
            state_in = ST_T1;
         end
         ST_T1: begin
            b_in = $signed(prod_ff) >>> 11;       // v1
            ma = a_ff; mb = a_ff;
            state_in = ST_T2;
         end
         ST_T2: begin
            ma = $signed(prod_ff) >>> 12; mb = t3;
            state_in = ST_T3;
         end
         ST_T3: begin
            fine_in = b_ff + asr(prod_ff, 5'd14);
            state_in = ST_T4;
         end
         ST_T4: begin
            ma = fine_ff; mb = 32'd5;
            state_in = ST_T5;
         end
         ST_T5: begin
            res_in.temperature_centideg = $signed(prod_ff + 32'd128) >>> 8;
            state_in = ST_DONE;
         end
         // ---------------- pressure ----------------
         ST_P0: begin
            a_in = asr(fine_ff, 5'd1) - 32'd64000;   // v1
            state_in = ST_P1;
         end
         ST_P1: begin
            ma = $signed(a_ff) >>> 2; mb = $signed(a_ff) >>> 2;   // q*q
            state_in = ST_P2;
         end
         ST_P2: begin
            c_in = prod_ff;                                      // q*q
            ma = $signed(prod_ff) >>> 11; mb = p6;
            state_in = ST_P3;
         end
         ST_P3: begin
            b_in = prod_ff;                                      // v2
            ma = a_ff; mb = p5;
            state_in = ST_P4;
         end
         ST_P4: begin
            b_in = asr(b_ff + (prod_ff << 1), 5'd2) + (p4 << 16);
            ma = p3; mb = $signed(c_ff) >>> 13;
            state_in = ST_P5;
         end
         ST_P5: begin
            c_in = $signed(prod_ff) >>> 3;
            ma = p2; mb = a_ff;
            state_in = ST_P6;
         end
         ST_P6: begin
            a_in = asr(c_ff + asr(prod_ff, 5'd1), 5'd18);
            state_in = ST_P7;
         end
         ST_P7: begin
            ma = 32'd32768 + a_ff; mb = p1;
            state_in = ST_P8;
         end
         ST_P8: begin
            c_in = $signed(prod_ff) >>> 15;                      // divisor
            ma = (32'd1048576 - {12'd0, adc_ff}) - asr(b_ff, 5'd12);
            mb = 32'd3125;
            state_in = ST_P9;
         end
         ST_P9: begin
            if (c_ff == '0) begin
               res_in.divide_by_zero = 1'b1;
               state_in = ST_DONE;
            end else begin
               a_in   = {31'd0, prod_ff[31]};                    // 1: divide then double
               quo_in = prod_ff[31] ? prod_ff : (prod_ff << 1);
               rem_in = '0;
               cnt_in = 6'd32;
               state_in = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = ST_P10;
         end
         ST_P10: begin
            a_in = a_ff[0] ? (quo_ff << 1) : quo_ff;             // p
            state_in = ST_P11;
         end
         ST_P11: begin
            ma = a_ff >> 3; mb = a_ff >> 3;
            state_in = ST_P12;
         end
         ST_P12: begin
            ma = p9; mb = prod_ff >> 13;
            state_in = ST_P13;
         end
         ST_P13: begin
            c_in = asr(prod_ff, 5'd12);                          // v1
            ma = a_ff >> 2; mb = p8;
            state_in = ST_P14;
         end
         ST_P14: begin
            res_in.pressure_pa = a_ff + asr(c_ff + asr(prod_ff, 5'd13) + p7, 5'd4);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sv/btpc_checker.sv @@
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks on the compensation core.
// ----------------------------------------------------------------------------
module btpc_checker
   import btpc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("ready right after accept");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.temperature_centideg == 0) || (rsp_data.pressure_pa == 0))
      else $error("both result fields nonzero");

endmodule

bind baro_temp_pressure_compensation_core btpc_checker u_btpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
